### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on the rising clock edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property.
`define GH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent now, consequent on the next edge.
`define GH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/ghalloc_pkg.sv
// ----------------------------------------------------------------------------
// ghalloc_pkg
// Types and constants shared by the handle allocator and its checker.
// ----------------------------------------------------------------------------
package ghalloc_pkg;

    localparam int MAX_ENTITIES = 1024;
    localparam int VERSION_BITS = 16;
    localparam int IDX_W        = $clog2(MAX_ENTITIES);
    localparam int CNT_W        = IDX_W + 1;
    localparam int VER_W        = VERSION_BITS;

    typedef enum logic [2:0] {
        KIND_CREATE   = 3'd0,
        KIND_RESERVE  = 3'd1,
        KIND_ACTIVATE = 3'd2,
        KIND_DESTROY  = 3'd3,
        KIND_CHECK    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_BAD  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [2:0]       kind;
        logic [IDX_W-1:0] entity_index;
        logic [VER_W-1:0] entity_version;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0] handle_index;
        logic [VER_W-1:0] handle_version;
        logic [1:0]       status;
        logic [CNT_W-1:0] live_count;
    } t_res;

    // One entry of the entity table.
    typedef struct packed {
        logic             alive;
        logic [VER_W-1:0] version;
    } t_entry;

endpackage

### hw/rtl/ghalloc_ram.sv
// ----------------------------------------------------------------------------
// ghalloc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ghalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/generational_handle_allocator.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator: index+version handles with a LIFO free list.
// Result strobe registered from the execute state; create/reserve that pops
// the free stack passes a pop state first (stack read, then entity read).
// A new transaction is taken only while idle, never before the last result.
// Sync reset clears counters at once; RAMs need no clearing pass.
// ----------------------------------------------------------------------------
module generational_handle_allocator
    import ghalloc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_res o_result
);

    // Entity table holds {alive, version} per index. Entries at or above the
    // used-index count were never written; they are treated as version 1, not
    // alive, which is what a fresh allocation substitutes instead of the RAM data.
    // Requests for such indices are rejected before the RAM data matters.

    t_state           r_state, n_state;
    t_req             r_req, n_req;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_fresh, n_fresh;   // never-used index, no RAM data
    logic             r_pop, n_pop;       // index came off the free stack
    logic             r_full, n_full;     // pool exhausted
    logic [CNT_W-1:0] r_free_top, n_free_top;
    logic [CNT_W-1:0] r_used, n_used;
    logic [CNT_W-1:0] r_alive_total, n_alive_total;
    logic             r_done, n_done;
    t_res             r_res, n_res;

    // RAM ports
    logic             ent_we;
    logic [IDX_W-1:0] ent_raddr;
    t_entry           ent_wdata;
    t_entry           ent_rdata;
    logic             stk_we;
    logic [IDX_W-1:0] stk_raddr;
    logic [IDX_W-1:0] stk_rdata;

    // Execute-stage helpers
    t_entry           cur;
    logic             in_range;
    logic             ver_match;
    logic             is_alloc;
    logic [VER_W-1:0] bumped;

    ghalloc_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_ENTITIES)
    ) u_entity_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (r_idx),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    ghalloc_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_ENTITIES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_free_top[IDX_W-1:0]),
        .i_wdata (r_idx),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign busy = (r_state != S_IDLE);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_free_top    <= '0;
            r_used        <= '0;
            r_alive_total <= '0;
            r_done        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_free_top    <= n_free_top;
            r_used        <= n_used;
            r_alive_total <= n_alive_total;
            r_done        <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_idx   <= n_idx;
        r_fresh <= n_fresh;
        r_pop   <= n_pop;
        r_full  <= n_full;
        r_res   <= n_res;
    end

    always_comb begin
        n_state       = r_state;
        n_req         = r_req;
        n_idx         = r_idx;
        n_fresh       = r_fresh;
        n_pop         = r_pop;
        n_full        = r_full;
        n_free_top    = r_free_top;
        n_used        = r_used;
        n_alive_total = r_alive_total;
        n_done        = 1'b0;
        n_res         = r_res;

        stk_raddr = r_free_top[IDX_W-1:0] - IDX_W'(1);
        ent_raddr = i_req.entity_index;
        ent_we    = 1'b0;
        ent_wdata = '0;
        stk_we    = 1'b0;

        is_alloc  = (r_req.kind == KIND_CREATE) || (r_req.kind == KIND_RESERVE);
        cur       = r_fresh ? t_entry'{alive: 1'b0, version: VER_W'(1)} : ent_rdata;
        in_range  = ({1'b0, r_idx} < r_used);
        ver_match = (cur.version == r_req.entity_version);
        bumped    = cur.version + VER_W'(1);
        if (bumped == '0) begin
            bumped = VER_W'(1);
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_idx   = i_req.entity_index;
                    n_fresh = 1'b0;
                    n_pop   = 1'b0;
                    n_full  = 1'b0;
                    n_state = S_EXEC;
                    if (i_req.kind == KIND_CREATE || i_req.kind == KIND_RESERVE) begin
                        if (r_free_top != '0) begin
                            // stack read issued now, data in S_POP
                            n_pop   = 1'b1;
                            n_state = S_POP;
                        end else if (r_used < CNT_W'(MAX_ENTITIES)) begin
                            n_idx   = r_used[IDX_W-1:0];
                            n_fresh = 1'b1;
                        end else begin
                            n_full  = 1'b1;
                        end
                    end
                end
            end

            S_POP: begin
                // popped index drives the entity read
                ent_raddr = stk_rdata;
                n_idx     = stk_rdata;
                n_state   = S_EXEC;
            end

            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                n_res   = '{handle_index: '0, handle_version: '0,
                            status: STAT_BAD, live_count: r_alive_total};
                if (is_alloc) begin
                    if (r_full) begin
                        n_res.status = STAT_FULL;
                    end else begin
                        if (r_pop) begin
                            n_free_top = r_free_top - CNT_W'(1);
                        end
                        if (r_fresh) begin
                            n_used = r_used + CNT_W'(1);
                        end
                        ent_we    = 1'b1;
                        ent_wdata = cur;
                        if (r_req.kind == KIND_CREATE) begin
                            ent_wdata.alive = 1'b1;
                            if (!cur.alive) begin
                                n_alive_total = r_alive_total + CNT_W'(1);
                            end
                        end
                        n_res.handle_index   = r_idx;
                        n_res.handle_version = cur.version;
                        n_res.status         = STAT_OK;
                    end
                end else begin
                    case (r_req.kind)
                        KIND_ACTIVATE: begin
                            if (in_range && !cur.alive && ver_match) begin
                                ent_we          = 1'b1;
                                ent_wdata       = cur;
                                ent_wdata.alive = 1'b1;
                                n_alive_total   = r_alive_total + CNT_W'(1);
                                n_res.status    = STAT_OK;
                            end
                        end
                        KIND_DESTROY: begin
                            if (in_range && cur.alive && ver_match) begin
                                ent_we    = 1'b1;
                                ent_wdata = '{alive: 1'b0, version: bumped};
                                if (r_alive_total != '0) begin
                                    n_alive_total = r_alive_total - CNT_W'(1);
                                end
                                // push dropped when the stack is full
                                if (r_free_top < CNT_W'(MAX_ENTITIES)) begin
                                    stk_we     = 1'b1;
                                    n_free_top = r_free_top + CNT_W'(1);
                                end
                                n_res.status = STAT_OK;
                            end
                        end
                        KIND_CHECK: begin
                            if (in_range && cur.alive && ver_match) begin
                                n_res.status = STAT_OK;
                            end
                        end
                        default: begin
                            // unknown kind: rejected, nothing changes
                        end
                    endcase
                end
                n_res.live_count = n_alive_total;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

### hw/rtl/ghalloc_checker.sv
// ----------------------------------------------------------------------------
// ghalloc_checker
// Port-level checks on the handle allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ghalloc_checker
    import ghalloc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_res o_result
);

    // A taken transaction keeps the block busy on the next cycle.
    `GH_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, start && !busy, busy, "not busy after take")

    // Each result closes a busy period.
    `GH_ASSERT(a_done_ends_busy, i_clk, i_rst_n, o_done |-> (!busy && $past(busy)), "stray result")

    // Status codes stay within the defined set.
    `GH_ASSERT(a_status_legal, i_clk, i_rst_n, o_done |-> (o_result.status == STAT_OK || o_result.status == STAT_FULL || o_result.status == STAT_BAD), "bad status")

    // Live count never exceeds the pool size.
    `GH_ASSERT(a_live_bound, i_clk, i_rst_n, o_done |-> (o_result.live_count <= CNT_W'(MAX_ENTITIES)), "live count overflow")

    // Failed requests hand out no handle.
    `GH_ASSERT(a_no_handle_on_fail, i_clk, i_rst_n, (o_done && o_result.status != STAT_OK) |-> (o_result.handle_index == '0 && o_result.handle_version == '0), "handle on failure")

endmodule

bind generational_handle_allocator ghalloc_checker u_ghalloc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

### tb/sv/generational_handle_allocator_test.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_test
// Self-checking bench for the handle allocator. A queue of requests feeds a
// clocked driver. An in-bench handle table predicts every reply when its
// transaction is taken, and a clocked monitor checks each strobed reply
// against the oldest prediction. Phases: directed corner cases, then
// weighted random traffic.
// ----------------------------------------------------------------------------
module generational_handle_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ghalloc_pkg::*;

    localparam int unsigned RUN_LIMIT    = 2_000_000; // cycles
    localparam int unsigned RANDOM_ITEMS = 426;
    localparam int unsigned TAIL_CYCLES  = 8;         // quiet time after last reply
    localparam int unsigned KIND_MAX     = 7;         // top of the 3-bit kind code
    localparam int unsigned QUEUE_AHEAD  = 4;         // requests queued ahead of driver

    // One queued request plus its pacing.
    typedef struct {
        t_req        req;
        int unsigned gap;    // idle cycles before presenting it
        bit          drain;  // hold until every reply is back
    } req_slot_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_res o_result;

    generational_handle_allocator DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Shadow handle table, updated as each transaction is taken.
    // ------------------------------------------------------------------------
    logic [VER_W-1:0] gen_table   [MAX_ENTITIES];
    bit               alive_map   [MAX_ENTITIES];
    logic [IDX_W-1:0] freed_stack [MAX_ENTITIES];
    int unsigned      freed_depth;
    int unsigned      issued_count;   // indices ever handed out
    int unsigned      live_total;

    req_slot_t   request_queue[$];
    t_res        expected_replies[$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned gap_left       = 0;
    bit          armed          = 0;  // head request has its gap loaded

    // Idle pattern state: alternate stretches of gaps and back-to-back traffic.
    int unsigned stretch_left = 0;
    bit          stretch_idle = 0;

    function automatic bit handle_live(logic [IDX_W-1:0] idx, logic [VER_W-1:0] ver);
        return idx < issued_count && alive_map[idx] && gen_table[idx] == ver;
    endfunction

    // Applies one request to the shadow table and returns its reply.
    function automatic t_res handle_table_step(t_req r);
        t_res             res;
        logic [IDX_W-1:0] idx;
        logic [VER_W-1:0] bumped;
        bit               got;
        res        = '0;
        res.status = STAT_BAD;
        idx        = r.entity_index;
        case (r.kind)
            KIND_CREATE, KIND_RESERVE: begin
                // LIFO reuse first, then fresh indices
                got = 1'b1;
                if (freed_depth > 0) begin
                    freed_depth--;
                    idx = freed_stack[freed_depth];
                end else if (issued_count < MAX_ENTITIES) begin
                    idx = IDX_W'(issued_count);
                    issued_count++;
                end else begin
                    got = 1'b0;
                end
                if (got) begin
                    // a popped index that was re-activated is not counted twice
                    if (r.kind == KIND_CREATE && !alive_map[idx]) begin
                        alive_map[idx] = 1'b1;
                        live_total++;
                    end
                    res.handle_index   = idx;
                    res.handle_version = gen_table[idx];
                    res.status         = STAT_OK;
                end else begin
                    res.status = STAT_FULL;
                end
            end
            KIND_ACTIVATE: begin
                if (idx < issued_count && !alive_map[idx] &&
                    gen_table[idx] == r.entity_version) begin
                    alive_map[idx] = 1'b1;
                    live_total++;
                    res.status = STAT_OK;
                end
            end
            KIND_DESTROY: begin
                if (handle_live(idx, r.entity_version)) begin
                    alive_map[idx] = 1'b0;
                    if (live_total > 0)
                        live_total--;
                    bumped = gen_table[idx] + 1'b1;
                    if (bumped == '0)
                        bumped = VER_W'(1);      // version zero is never handed out
                    gen_table[idx] = bumped;
                    // push silently dropped once the stack is full
                    if (freed_depth < MAX_ENTITIES) begin
                        freed_stack[freed_depth] = idx;
                        freed_depth++;
                    end
                    res.status = STAT_OK;
                end
            end
            KIND_CHECK: begin
                if (handle_live(idx, r.entity_version))
                    res.status = STAT_OK;
            end
            default: ;
        endcase
        res.live_count = CNT_W'(live_total);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents the head request, honoring its gap and drain hold.
    // A transaction is taken at an edge with start high and busy low.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_requests
        bit present;
        present = 1'b0;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ENTITIES; i++) begin
                gen_table[i] = VER_W'(1);
                alive_map[i] = 1'b0;
                freed_stack[i] = '0;
            end
            freed_depth  = 0;
            issued_count = 0;
            live_total   = 0;
            armed        = 1'b0;
            start   <= 1'b0;
            i_req   <= '0;
        end else begin
            if (start && !busy) begin
                expected_replies.insert(expected_replies.size(), handle_table_step(i_req));
                void'(request_queue.pop_front());
                armed = 1'b0;
            end
            if (!armed && request_queue.size() > 0) begin
                gap_left = request_queue[0].gap;
                armed    = 1'b1;
            end
            if (armed) begin
                if (request_queue[0].drain && expected_replies.size() > 0)
                    present = 1'b0;
                else if (gap_left > 0)
                    gap_left--;
                else
                    present = 1'b1;
            end
            // single assignment per edge so a held start never glitches
            start <= present;
            if (present)
                i_req <= request_queue[0].req;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: replies cannot be stalled, so every strobe is checked at once.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_replies
        t_res want;
        if (i_rst_n) begin
            if ($isunknown(o_done)) begin
                report_mismatch("reply strobe unknown");
            end else if (o_done) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("reply strobe with no transaction outstanding");
                end else begin
                    want = expected_replies.pop_front();
                    if (o_result.handle_index !== want.handle_index)
                        report_mismatch($sformatf("handle_index %0d, want %0d",
                            o_result.handle_index, want.handle_index));
                    if (o_result.handle_version !== want.handle_version)
                        report_mismatch($sformatf("handle_version %0d, want %0d",
                            o_result.handle_version, want.handle_version));
                    if (o_result.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                            o_result.status, want.status));
                    if (o_result.live_count !== want.live_count)
                        report_mismatch($sformatf("live_count %0d, want %0d",
                            o_result.live_count, want.live_count));
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. The tasks among them wait on the falling edge, away
    // from the driver and monitor.
    // ------------------------------------------------------------------------
    task automatic push_request(input int unsigned kind, input int unsigned idx,
                                input int unsigned ver, input int unsigned gap,
                                input bit drain);
        req_slot_t slot;
        while (request_queue.size() >= QUEUE_AHEAD)
            @(negedge i_clk);
        slot.req.kind           = 3'(kind);
        slot.req.entity_index   = IDX_W'(idx);
        slot.req.entity_version = VER_W'(ver);
        slot.gap                = gap;
        slot.drain              = drain;
        request_queue.insert(request_queue.size(), slot);
    endtask

    task automatic wait_until_drained();
        while (request_queue.size() != 0 || expected_replies.size() != 0)
            @(negedge i_clk);
    endtask

    // Stretches of idling alternate with stretches of back-to-back traffic.
    function automatic int unsigned draw_gap();
        if (stretch_left == 0) begin
            stretch_left = $urandom_range(8, 40);
            stretch_idle = $urandom_range(0, 1);
        end
        stretch_left--;
        return stretch_idle ? $urandom_range(0, 8) : 0;
    endfunction

    // Random index, from those handed out once any are, preferring the wanted alive state.
    function automatic int unsigned pick_index(bit want_alive);
        int unsigned idx;
        idx = $urandom_range(0, MAX_ENTITIES - 1);
        if (issued_count == 0)
            return idx;
        for (int k = 0; k < 8; k++) begin
            idx = $urandom_range(0, issued_count - 1);
            if (alive_map[idx] == want_alive)
                break;
        end
        return idx;
    endfunction

    initial begin : stimulus
        int unsigned      sel;
        int unsigned      kind;
        int unsigned      idx;
        int unsigned      ver;

        while (i_rst_n !== 1'b1)
            @(negedge i_clk);

        // --- directed: never-issued handles, reserve/activate, stale
        // versions, reuse of a re-activated freed index, unknown kinds
        push_request(KIND_CHECK,    0, 1, draw_gap(), 1'b0);
        push_request(KIND_ACTIVATE, 0, 1, draw_gap(), 1'b0);
        push_request(KIND_DESTROY,  0, 1, draw_gap(), 1'b0);
        push_request(KIND_CREATE,   0, 0, draw_gap(), 1'b0);   // idx 0, ver 1
        push_request(KIND_RESERVE,  0, 0, draw_gap(), 1'b0);   // idx 1, inactive
        push_request(KIND_CHECK,    1, 1, draw_gap(), 1'b0);   // reserved: invalid
        push_request(KIND_ACTIVATE, 1, 2, draw_gap(), 1'b0);   // wrong version
        push_request(KIND_ACTIVATE, 1, 1, draw_gap(), 1'b0);
        push_request(KIND_ACTIVATE, 1, 1, draw_gap(), 1'b0);   // already alive
        push_request(KIND_DESTROY,  0, 2, draw_gap(), 1'b0);   // wrong version
        push_request(KIND_DESTROY,  0, 1, draw_gap(), 1'b0);   // idx 0 -> ver 2, stacked
        push_request(KIND_CHECK,    0, 1, draw_gap(), 1'b0);   // stale handle
        push_request(KIND_ACTIVATE, 0, 2, draw_gap(), 1'b0);   // alive while stacked
        push_request(KIND_CREATE,   0, 0, draw_gap(), 1'b1);   // pops 0, no double count
        push_request(KIND_CHECK,    0, 2, draw_gap(), 1'b0);
        push_request(KIND_DESTROY,  0, 2, draw_gap(), 1'b0);
        push_request(KIND_RESERVE,  0, 0, draw_gap(), 1'b0);   // pops 0 inactive
        push_request(KIND_DESTROY,  0, 3, draw_gap(), 1'b0);   // not alive
        push_request(KIND_ACTIVATE, 0, 3, draw_gap(), 1'b0);
        for (int k = int'(KIND_CHECK) + 1; k <= KIND_MAX; k++)
            push_request(k, MAX_ENTITIES - 1, '1, draw_gap(), 1'b0);
        push_request(KIND_CHECK,  MAX_ENTITIES - 1, '1, draw_gap(), 1'b0);
        push_request(KIND_CREATE, MAX_ENTITIES - 1, '1, draw_gap(), 1'b0);
        wait_until_drained();

        // --- weighted random traffic, handles drawn from the shadow table
        repeat (RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            idx = $urandom_range(0, MAX_ENTITIES - 1);
            ver = $urandom_range(0, (1 << VER_W) - 1);
            if (sel < 22) begin
                kind = KIND_CREATE;
            end else if (sel < 32) begin
                kind = KIND_RESERVE;
            end else if (sel < 87) begin
                if (sel < 47) begin
                    kind = KIND_ACTIVATE;
                    idx  = pick_index(1'b0);
                end else if (sel < 72) begin
                    kind = KIND_DESTROY;
                    idx  = pick_index(1'b1);
                end else begin
                    kind = KIND_CHECK;
                    idx  = pick_index($urandom_range(0, 1));
                end
                ver = gen_table[idx];
                // occasional stale or corrupted version
                if ($urandom_range(0, 99) < 15)
                    ver = ver ^ (1 << $urandom_range(0, VER_W - 1));
            end else if (sel < 90) begin
                kind = $urandom_range(int'(KIND_CHECK) + 1, KIND_MAX);
            end else begin
                kind = $urandom_range(0, KIND_MAX);
            end
            push_request(kind, idx, ver, draw_gap(), $urandom_range(0, 39) == 0);
        end

        wait_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
